// File: hw/rtl/delta_row_telemetry_encoder_defines.svh
// Assertion macros shared by the delta row telemetry encoder RTL.
`ifndef DELTA_ROW_TELEMETRY_ENCODER_DEFINES_SVH
`define DELTA_ROW_TELEMETRY_ENCODER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define DRTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drte assertion failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define DRTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drte assertion failed");
`else
`define DRTE_ASSERT_IMPL(label, ante, cons)
`define DRTE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/drte_pkg.sv
// Shared types and constants of the delta row telemetry encoder.
package drte_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLS = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFRESH  = 4'd1;

  // Register reset values and the refresh counter limit.
  localparam logic [4:0]  NUM_COLS_RST = 5'd16;
  localparam logic [15:0] REFRESH_RST  = 16'd0;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;

  // Encoding constants.
  localparam logic [7:0]  RAW32_PREFIX = 8'hE0;
  localparam logic [7:0]  D2_PREFIX    = 8'h80;
  localparam logic [7:0]  D2_SIGN      = 8'h20;
  localparam logic [7:0]  D3_PREFIX    = 8'hC0;
  localparam logic [7:0]  D3_SIGN      = 8'h10;
  localparam logic [31:0] D2_MAX       = 32'h0000_1FFF;
  localparam logic [31:0] D3_MAX       = 32'h000F_FFFF;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // One encoded value: bytes left-aligned, first byte in the top bits.
  typedef struct packed {
    logic [39:0] bytes;
    logic [2:0]  nbytes;
    logic        row_end;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic row_origin;
  } fstat_t;

endpackage

// File: hw/rtl/drte_front.sv
// Front end: accepts column values, tracks rows and encodes each value.
module drte_front #(
  parameter int MAX_COLS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // sample_value
  input  logic                            in_tuser,   // restart
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drte_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [drte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            q_full,
  output logic                            push,
  output drte_pkg::entry_t                push_entry,
  output drte_pkg::fstat_t                fstat
);

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [6:0] MAXC = 7'(MAX_COLS);

  logic [4:0]     num_cols_r, num_cols_nxt;
  logic [15:0]    ori_r, ori_nxt;
  logic [CIW-1:0] col_r, col_nxt;
  logic [15:0]    cnt_r, cnt_nxt;
  logic           seen_r, seen_nxt;
  logic           rorig_r, rorig_nxt;
  logic [31:0]    prev_r [MAX_COLS];

  logic           accept;
  logic [CIW-1:0] col_eff;
  logic           first_col;
  logic           refresh;
  logic           origin_now;
  logic [31:0]    last_val;
  logic           up;
  logic [31:0]    mag;
  logic [6:0]     ncols;
  logic [6:0]     col_p1;
  logic           row_end;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept;

  // Column and row decision for the value on the input.
  always_comb begin
    col_eff    = in_tuser ? '0 : col_r;
    first_col  = (col_eff == '0);
    refresh    = (ori_r != 16'd0) && (cnt_r >= ori_r);
    origin_now = first_col ? (in_tuser || !seen_r || refresh) : rorig_r;
  end

  // Active column count, clamped to 1..MAX_COLS, and row end.
  always_comb begin
    ncols = 7'(num_cols_r);
    if (ncols == 7'd0) begin
      ncols = 7'd1;
    end else if (ncols > MAXC) begin
      ncols = MAXC;
    end
    col_p1  = 7'(col_eff) + 7'd1;
    row_end = (col_p1 >= ncols);
  end

  // Difference from the column's last value.
  always_comb begin
    last_val = prev_r[col_eff];
    up       = (in_tdata >= last_val);
    mag      = up ? (in_tdata - last_val) : (last_val - in_tdata);
  end

  // Byte encoding of the value.
  always_comb begin
    push_entry.row_end = row_end;
    if (!origin_now && (mag <= drte_pkg::D2_MAX)) begin
      push_entry.bytes  = {drte_pkg::D2_PREFIX | (up ? drte_pkg::D2_SIGN : 8'd0)
                           | {3'd0, mag[12:8]}, mag[7:0], 24'd0};
      push_entry.nbytes = 3'd2;
    end else if (!origin_now && (mag <= drte_pkg::D3_MAX)) begin
      push_entry.bytes  = {drte_pkg::D3_PREFIX | (up ? drte_pkg::D3_SIGN : 8'd0)
                           | {4'd0, mag[19:16]}, mag[15:0], 16'd0};
      push_entry.nbytes = 3'd3;
    end else if (in_tdata[31]) begin
      push_entry.bytes  = {drte_pkg::RAW32_PREFIX, in_tdata};
      push_entry.nbytes = 3'd5;
    end else begin
      push_entry.bytes  = {1'b0, in_tdata[30:0], 8'd0};
      push_entry.nbytes = 3'd4;
    end
  end

  // Next state of the row tracking and configuration registers.
  always_comb begin
    num_cols_nxt = num_cols_r;
    ori_nxt      = ori_r;
    col_nxt      = col_r;
    cnt_nxt      = cnt_r;
    seen_nxt     = seen_r;
    rorig_nxt    = rorig_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        drte_pkg::CFG_NUM_COLS: num_cols_nxt = cfg_wdata[4:0];
        drte_pkg::CFG_REFRESH:  ori_nxt      = cfg_wdata[15:0];
        default: ;
      endcase
    end
    if (accept) begin
      col_nxt = row_end ? '0 : col_p1[CIW-1:0];
      if (first_col) begin
        rorig_nxt = origin_now;
        if (origin_now) begin
          seen_nxt = 1'b1;
          cnt_nxt  = 16'd0;
        end else if (cnt_r != drte_pkg::CNT_MAX) begin
          cnt_nxt  = cnt_r + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= drte_pkg::NUM_COLS_RST;
      ori_r      <= drte_pkg::REFRESH_RST;
      col_r      <= '0;
      cnt_r      <= 16'd0;
      seen_r     <= 1'b0;
      rorig_r    <= 1'b0;
    end else begin
      num_cols_r <= num_cols_nxt;
      ori_r      <= ori_nxt;
      col_r      <= col_nxt;
      cnt_r      <= cnt_nxt;
      seen_r     <= seen_nxt;
      rorig_r    <= rorig_nxt;
    end
  end

  // Last value of each column.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_r[col_eff] <= in_tdata;
    end
  end

  assign fstat.row_origin = rorig_r;

endmodule

// File: hw/rtl/drte_queue.sv
// Short queue of encoded values between the front and the back.
module drte_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  drte_pkg::entry_t push_entry,
  input  logic             pop,
  output drte_pkg::entry_t head,
  output drte_pkg::qstat_t qstat
);

  drte_pkg::entry_t             mem_r [drte_pkg::Q_DEPTH];
  logic [drte_pkg::Q_AW-1:0]    wr_r, wr_nxt;
  logic [drte_pkg::Q_AW-1:0]    rd_r, rd_nxt;
  logic [drte_pkg::Q_AW:0]      cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == (drte_pkg::Q_AW + 1)'(drte_pkg::Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = push ? wr_r + (drte_pkg::Q_AW)'(1) : wr_r;
    rd_nxt  = pop ? rd_r + (drte_pkg::Q_AW)'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (drte_pkg::Q_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (drte_pkg::Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

// File: hw/rtl/drte_back.sv
// Back end: serializes queued values into one output byte per transaction.
module drte_back (
  input  logic             clk,
  input  logic             rst_n,
  input  drte_pkg::entry_t head,
  input  drte_pkg::qstat_t qstat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // code_byte
  output logic             out_tlast,   // last_of_value
  output logic             out_tuser    // row_end
);

  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        rend_r, rend_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        slot_free;

  assign slot_free = !vld_r || out_tready;
  assign pop       = slot_free && (rem_r == 3'd0) && !qstat.empty;

  // Pick the next byte: rest of the current value, else a new queue head.
  always_comb begin
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    rend_nxt = rend_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (slot_free) begin
      if (rem_r != 3'd0) begin
        vld_nxt  = 1'b1;
        byte_nxt = sh_r[31:24];
        last_nxt = (rem_r == 3'd1);
        sh_nxt   = {sh_r[23:0], 8'd0};
        rem_nxt  = rem_r - 3'd1;
      end else if (!qstat.empty) begin
        vld_nxt  = 1'b1;
        byte_nxt = head.bytes[39:32];
        last_nxt = (head.nbytes == 3'd1);
        rend_nxt = head.row_end;
        sh_nxt   = head.bytes[31:0];
        rem_nxt  = head.nbytes - 3'd1;
      end else begin
        vld_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    rend_r <= rend_nxt;
    sh_r   <= sh_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = rend_r;

endmodule

// File: hw/rtl/delta_row_telemetry_encoder.sv
// Top level of the delta row telemetry encoder.
// Each input transaction carries one 32-bit column value and a restart flag;
// each output transaction carries one byte of its encoding, most significant
// first, with tlast on the final byte of the value and tuser set on every
// byte of a value that closes a row. A value yields 2 to 5 bytes (5 for raw
// values with bit 31 set, 4 for other raw values, 3 or 2 for deltas); the
// byte serializer in the back end pops the next value only once the last
// byte of the current one is loaded. The front end takes one value per cycle
// while the 4-entry queue has room, so short bursts enter back to back; the
// first byte of a value passes through the queue and the output byte register
// before it is presented. Configuration writes are always ready and take
// effect at once; write them only while no value is in flight.
`include "delta_row_telemetry_encoder_defines.svh"

module delta_row_telemetry_encoder #(
  parameter int MAX_COLS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // sample_value
  input  logic                            in_tuser,   // restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // code_byte
  output logic                            out_tlast,  // last_of_value
  output logic                            out_tuser,  // row_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drte_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [drte_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic             push;
  logic             pop;
  drte_pkg::entry_t push_entry;
  drte_pkg::entry_t head;
  drte_pkg::qstat_t qstat;
  drte_pkg::fstat_t fstat;

  drte_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_full     (qstat.full),
    .push       (push),
    .push_entry (push_entry),
    .fstat      (fstat)
  );

  drte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  drte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // The queue is never full and empty at once.
  `DRTE_ASSERT_IMPL(a_queue_count, qstat.full, !qstat.empty)
  // A restarting value always opens an origin row.
  `DRTE_ASSERT_NEXT(a_restart_origin, in_tvalid && in_tready && in_tuser, fstat.row_origin)
  // The bytes of one value leave without a gap once the first is taken.
  `DRTE_ASSERT_NEXT(a_value_no_gap, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule
